// ===== src/sdsu_pkg.sv =====
// Shared types and constants for the string delimiter splitter.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package sdsu_pkg;

  localparam int MAX_DELIM_LEN_DEF = 8;
  localparam int BYTE_W            = 8;
  localparam int LEN_W             = 4;
  localparam int DELIM_W           = 64;
  localparam int CFG_IDX_W         = 1;
  localparam int KIND_W            = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DATA      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIELD_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT_END  = 2'd2;

  // Request actions
  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 1'd1;

  localparam logic [DELIM_W-1:0] DELIM_BYTES_RST = '0;
  localparam logic [LEN_W-1:0]   DELIM_LEN_RST   = 4'd1;

  // Per-cycle command shared by every window cell
  typedef struct packed {
    logic shift;  // take the neighbor's forwarded byte
    logic load;   // the cell at the write position takes the new byte
  } cell_ctrl_t;

endpackage

// ===== src/sdsu_if.sv =====
// Valid/ready channels of the string delimiter splitter: input, result, config write.
// Depends on sdsu_pkg for field widths.
`timescale 1ns / 1ps

interface sdsu_in_if import sdsu_pkg::*;;
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface sdsu_out_if import sdsu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

interface sdsu_cfg_if import sdsu_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DELIM_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/string_delimiter_splitter_unit.sv =====
// Channel  Dir  Payload                      Handshake
// in_ch    in   action, data_byte            valid/ready
// out_ch   out  kind, out_byte, last         valid/ready
// cfg      in   index, data                  valid/ready (ready always high)
//
// A request is taken into a holding register and issued one result per cycle while the
// output is not stalled. A text byte with at most one result completes in the step that
// handles it, so such requests flow at one per cycle; end of text issues each pending byte
// and then the text end; after a shortened delimiter, excess pending bytes go out first.
// Reset (rst, synchronous) clears the pending count, holding and output valids.
// A stalled result holds in the output register; the holding stage and the cells stall too.
`timescale 1ns / 1ps

module string_delimiter_splitter_unit import sdsu_pkg::*; #(
  parameter int MAX_DELIM_LEN = MAX_DELIM_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sdsu_in_if.sink     in_ch,
  sdsu_out_if.source  out_ch,
  sdsu_cfg_if.sink    cfg
);

  localparam int CNT_W = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

  // Configuration
  logic [DELIM_W-1:0] delim;
  logic [LEN_W-1:0]   dlen;

  // Holding stage
  logic              cur_valid;
  logic              cur_action;
  logic [BYTE_W-1:0] cur_byte;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // Output register
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last;

  logic              adv;
  logic              emit;
  logic              done;
  logic [KIND_W-1:0] emit_kind;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  cell_ctrl_t        ctrl;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  cnt4;
  logic [BYTE_W-1:0] fwd [MAX_DELIM_LEN];
  logic [MAX_DELIM_LEN-1:0] eq;
  logic [MAX_DELIM_LEN-1:0] mask;
  logic              match;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim <= DELIM_BYTES_RST;
      dlen  <= DELIM_LEN_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_DELIM_BYTES) begin
        delim <= cfg.data;
      end else begin
        dlen <= cfg.data[LEN_W-1:0];
      end
    end
  end

  // Active length, clamped to 1..MAX_DELIM_LEN
  always_comb begin
    if (dlen == '0) begin
      len = LEN_W'(1);
    end else if (dlen > LEN_W'(MAX_DELIM_LEN)) begin
      len = LEN_W'(MAX_DELIM_LEN);
    end else begin
      len = dlen;
    end
  end

  assign cnt4 = LEN_W'(count);

  // Row of window cells; the incoming byte acts as the top position
  assign fwd[MAX_DELIM_LEN-1] = cur_byte;
  assign eq[MAX_DELIM_LEN-1]  = (cur_byte == delim[BYTE_W*(MAX_DELIM_LEN-1) +: BYTE_W]);

  for (genvar i = 0; i < MAX_DELIM_LEN - 1; i++) begin : g_cell
    sdsu_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .here       (count == CNT_W'(i)),
      .new_byte   (cur_byte),
      .delim_byte (delim[BYTE_W*i +: BYTE_W]),
      .right_fwd  (fwd[i+1]),
      .fwd        (fwd[i]),
      .eq         (eq[i])
    );
  end

  for (genvar i = 0; i < MAX_DELIM_LEN; i++) begin : g_mask
    assign mask[i] = (LEN_W'(i) < len);
  end

  assign match = &(eq | ~mask);

  assign adv = !out_valid || out_ch.ready;

  always_comb begin
    emit       = 1'b0;
    done       = 1'b0;
    emit_kind  = KIND_DATA;
    emit_byte  = '0;
    emit_last  = 1'b0;
    ctrl       = '0;
    count_next = count;
    if (cur_valid && adv) begin
      if (cur_action == ACT_END) begin
        if (count != '0) begin
          // flush the oldest pending byte
          emit       = 1'b1;
          emit_byte  = fwd[0];
          ctrl.shift = 1'b1;
          count_next = count - CNT_W'(1);
        end else begin
          emit      = 1'b1;
          emit_kind = KIND_TEXT_END;
          emit_last = 1'b1;
          done      = 1'b1;
        end
      end else if (cnt4 >= len) begin
        // emit excess left by a shortened delimiter as data, no compare
        emit       = 1'b1;
        emit_byte  = fwd[0];
        ctrl.shift = 1'b1;
        count_next = count - CNT_W'(1);
      end else if (cnt4 + LEN_W'(1) == len) begin
        emit      = 1'b1;
        emit_last = 1'b1;
        done      = 1'b1;
        if (match) begin
          emit_kind  = KIND_FIELD_END;
          count_next = '0;
        end else begin
          emit_byte  = fwd[0];
          ctrl.shift = 1'b1;
        end
      end else begin
        ctrl.load  = 1'b1;
        count_next = count + CNT_W'(1);
        done       = 1'b1;
      end
    end
  end

  assign in_ch.ready = !cur_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_ch.valid && in_ch.ready) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cur_action <= in_ch.action;
      cur_byte   <= in_ch.data_byte;
    end
    if (emit) begin
      out_kind   <= emit_kind;
      out_byte_q <= emit_byte;
      out_last   <= emit_last;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.kind     = out_kind;
  assign out_ch.out_byte = out_byte_q;
  assign out_ch.last     = out_last;

  a_text_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_TEXT_END |-> out_last)
    else $error("text end result without last");

  a_only_data_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_kind == KIND_DATA)
    else $error("non-data result before the last one");

  a_field_end_clears: assert property (@(posedge clk) disable iff (rst)
    emit && emit_kind == KIND_FIELD_END |=> count == '0)
    else $error("window not cleared after field end");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> in_ch.ready)
    else $error("empty holding stage refuses requests");

endmodule

// ===== src/sdsu_cell.sv =====
// One window cell: holds a pending byte, compares it with its delimiter byte,
// and hands its byte to the left neighbor on a shift. Depends on sdsu_pkg.
`timescale 1ns / 1ps

module sdsu_cell import sdsu_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              here,       // this cell is the write position
  input  logic [BYTE_W-1:0] new_byte,
  input  logic [BYTE_W-1:0] delim_byte,
  input  logic [BYTE_W-1:0] right_fwd,  // forwarded byte of the right neighbor
  output logic [BYTE_W-1:0] fwd,
  output logic              eq
);

  logic [BYTE_W-1:0] held;

  // The new byte stands in for this cell when it lands here this cycle
  assign fwd = here ? new_byte : held;
  assign eq  = (fwd == delim_byte);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= right_fwd;
    end else if (ctrl.load && here) begin
      held <= new_byte;
    end
  end

endmodule

// ===== tb/string_delimiter_splitter_unit_test.sv =====
// Self-checking testbench for string_delimiter_splitter_unit: directed table, then random phases.
// Depends on sdsu_pkg and the sdsu_in_if, sdsu_out_if and sdsu_cfg_if interfaces.
`timescale 1ns / 1ps

module string_delimiter_splitter_unit_test;
  import sdsu_pkg::*;

  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_CYCLES    = 32;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASE_ITEMS     = 25;
  localparam int NUM_PHASES      = 12;
  localparam int NUM_ROWS        = 28;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } split_result_t;

  typedef enum logic [1:0] {ROW_TEXT, ROW_END, ROW_CFG} row_op_e;

  typedef struct packed {
    row_op_e              op;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DELIM_W-1:0]   value;   // text byte, or register data for ROW_CFG
    logic                 typed;   // expected result given in the row
    split_result_t        result;
  } stim_row_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam split_result_t NO_RESULT = '0;
  localparam logic [DELIM_W-1:0] ALL_ONES = '1;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // reset setting: single zero byte delimiter
    '{ROW_END,  REG_DELIM_BYTES, 64'hFF, 1'b1, '{KIND_TEXT_END, 8'h00, 1'b1}},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h00, 1'b1, '{KIND_FIELD_END, 8'h00, 1'b1}},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'hFF, 1'b1, '{KIND_DATA, 8'hFF, 1'b1}},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h80, 1'b1, '{KIND_DATA, 8'h80, 1'b1}},
    '{ROW_END,  REG_DELIM_BYTES, 64'h00, 1'b1, '{KIND_TEXT_END, 8'h00, 1'b1}},
    // three byte delimiter, with a false start
    '{ROW_CFG,  REG_DELIM_BYTES, 64'h8877665544332211, 1'b0, NO_RESULT},
    '{ROW_CFG,  REG_DELIM_LEN,   64'd3,  1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h11, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h22, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h33, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h11, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h11, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h22, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h33, 1'b0, NO_RESULT},
    // leave two bytes pending, then shorten the delimiter
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h11, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h22, 1'b0, NO_RESULT},
    '{ROW_CFG,  REG_DELIM_LEN,   64'd1,  1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'h11, 1'b0, NO_RESULT},
    // longest delimiter, seven pending bytes flushed by end of text
    '{ROW_CFG,  REG_DELIM_BYTES, ALL_ONES, 1'b0, NO_RESULT},
    '{ROW_CFG,  REG_DELIM_LEN,   64'd8,  1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'hFF, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'hFF, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'hFF, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'hFF, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'hFF, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'hFF, 1'b0, NO_RESULT},
    '{ROW_TEXT, REG_DELIM_BYTES, 64'hFF, 1'b0, NO_RESULT},
    '{ROW_END,  REG_DELIM_BYTES, 64'h00, 1'b0, NO_RESULT}
  };

  // Includes the out-of-range lengths 0 and 15
  localparam logic [LEN_W-1:0] PHASE_LENGTHS [NUM_PHASES] = '{
    4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd7, 4'd4, 4'd6, 4'd2, 4'd8
  };

  logic clk;
  logic rst;

  sdsu_in_if  in_ch ();
  sdsu_out_if out_ch ();
  sdsu_cfg_if cfg_ch ();

  string_delimiter_splitter_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // Predictor copy of the block
  logic [DELIM_W-1:0] delim_bytes;
  logic [LEN_W-1:0]   delim_len;
  logic [BYTE_W-1:0]  held_bytes [$];

  split_result_t split_results_due [$];
  int            error_count;
  int            cycle_count;
  int            send_gap_pct;
  int            recv_stall_pct;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int active_len(logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_DELIM_LEN_DEF) return MAX_DELIM_LEN_DEF;
    return int'(len);
  endfunction

  // Results caused by one request; advances the pending window.
  function automatic void split_text(input logic act, input logic [BYTE_W-1:0] b,
                                     ref split_result_t res [$]);
    int   len;
    logic hit;
    len = active_len(delim_len);
    res.delete();
    if (act == ACT_END) begin
      while (held_bytes.size() > 0)
        res.insert(res.size(), split_result_t'{KIND_DATA, held_bytes.pop_front(), 1'b0});
      res.insert(res.size(), split_result_t'{KIND_TEXT_END, 8'h00, 1'b0});
    end else begin
      // excess left by a shortened delimiter leaves uncompared
      while (held_bytes.size() > len - 1)
        res.insert(res.size(), split_result_t'{KIND_DATA, held_bytes.pop_front(), 1'b0});
      held_bytes.insert(held_bytes.size(), b);
      if (held_bytes.size() == len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++)
          if (held_bytes[i] != delim_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          held_bytes.delete();
          res.insert(res.size(), split_result_t'{KIND_FIELD_END, 8'h00, 1'b0});
        end else begin
          res.insert(res.size(), split_result_t'{KIND_DATA, held_bytes.pop_front(), 1'b0});
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
  endfunction

  task automatic set_idling(idle_mode_e mode);
    send_gap_pct   = (mode == IDLE_SENDER)   ? 64 : (mode == IDLE_BOTH) ? 33 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 64 : (mode == IDLE_BOTH) ? 33 : 0;
  endtask

  // Call after the last accept or at a falling edge; leaves valid high after accept.
  task automatic send_request(input logic act, input logic [BYTE_W-1:0] b,
                              input logic typed, input split_result_t typed_res);
    split_result_t res [$];
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    split_text(act, b, res);
    if (typed) split_results_due.insert(split_results_due.size(), typed_res);
    else foreach (res[i]) split_results_due.insert(split_results_due.size(), res[i]);
  endtask

  // Drop valid, drain all results, then let any resultless request finish.
  task automatic wait_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (split_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELIM_W-1:0] val);
    wait_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_DELIM_BYTES) delim_bytes = val;
    else delim_len = val[LEN_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    split_result_t due;
    split_result_t seen;
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.kind, out_ch.out_byte, out_ch.last};
      if (split_results_due.size() == 0) begin
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0b",
                 $time, seen.kind, seen.out_byte, seen.last);
        error_count++;
      end else begin
        due = split_results_due.pop_front();
        if (seen !== due) begin
          $display("%0t: mismatch expected kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
                   $time, due.kind, due.out_byte, due.last, seen.kind, seen.out_byte, seen.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0]  alpha_a;
    logic [BYTE_W-1:0]  alpha_b;
    logic [DELIM_W-1:0] pattern;
    int                 eff_len;
    int                 sent;
    int                 pick;
    int                 run_len;

    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_TEXT;
    in_ch.data_byte  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_DELIM_BYTES;
    cfg_ch.data      = '0;
    delim_bytes      = DELIM_BYTES_RST;
    delim_len        = DELIM_LEN_RST;
    error_count      = 0;
    cycle_count      = 0;
    set_idling(IDLE_NONE);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].op == ROW_CFG)
        write_reg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value);
      else
        send_request(DIRECTED_ROWS[r].op == ROW_END ? ACT_END : ACT_TEXT,
                     DIRECTED_ROWS[r].value[BYTE_W-1:0],
                     DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // two-letter delimiters give overlapping near matches; two phases use the extremes
      if (p == 2) begin
        alpha_a = 8'h00;
        alpha_b = 8'h00;
      end else if (p == 3) begin
        alpha_a = 8'hFF;
        alpha_b = 8'hFF;
      end else begin
        alpha_a = 8'($urandom_range(0, 255));
        alpha_b = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < 8; i++) pattern[8*i +: 8] = $urandom_range(0, 1) ? alpha_a : alpha_b;

      // pending bytes stay across the writes, so shortening is hit too
      write_reg(REG_DELIM_BYTES, pattern);
      write_reg(REG_DELIM_LEN, {60'({$urandom, $urandom}), PHASE_LENGTHS[p]});
      set_idling(idle_mode_e'(p % 4));
      eff_len = active_len(PHASE_LENGTHS[p]);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          // whole delimiter, or a prefix cut short
          run_len = (pick < 20) ? eff_len : $urandom_range(1, eff_len);
          for (int i = 0; i < run_len; i++)
            send_request(ACT_TEXT, delim_bytes[8*i +: 8], 1'b0, NO_RESULT);
          sent += run_len;
        end else begin
          if (pick < 40)
            send_request(ACT_END, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
          else if (pick < 75)
            send_request(ACT_TEXT, $urandom_range(0, 1) ? alpha_a : alpha_b, 1'b0, NO_RESULT);
          else
            send_request(ACT_TEXT, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
          sent++;
        end
      end
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
